FILE: src/cdsc_pkg.sv
// Shared types and constants of the clock digit set controller.
`default_nettype none

package cdsc_pkg;

   // Event kinds carried on the request tuser.
   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_ENTER = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   localparam int unsigned NUM_DIGITS      = 4;
   localparam logic [7:0]  TIMEOUT_RESET   = 8'd20;
   localparam logic [5:0]  HOURS_PER_DAY   = 6'd24;
   localparam logic [6:0]  MINUTES_PER_HR  = 7'd60;
   localparam logic [3:0]  HOUR_TENS_MOD   = 4'd3;
   localparam logic [3:0]  MINUTE_TENS_MOD = 4'd6;
   localparam logic [3:0]  UNITS_MOD       = 4'd10;

   // Digit positions inside the digit store.
   localparam logic [1:0] DIG_HOUR_TENS   = 2'd0;
   localparam logic [1:0] DIG_MINUTE_TENS = 2'd2;
   localparam logic [1:0] DIG_MINUTE_UNITS = 2'd3;

   // One request beat, unpacked.
   typedef struct packed {
      cmd_type    cmd;
      logic       edit_sample_first;
      logic       edit_sample_second;
      logic       set_button_level;
      logic [4:0] rtc_hour;
      logic [5:0] rtc_minute;
   } req_item_type;

   // One response beat, unpacked.
   typedef struct packed {
      logic       in_set_mode;
      logic [1:0] hour_tens;
      logic [3:0] hour_units;
      logic [2:0] minute_tens;
      logic [3:0] minute_units;
      logic [3:0] blink_mask;
      logic       commit_valid;
      logic [4:0] commit_hour;
      logic [5:0] commit_minute;
   } rsp_item_type;

   // Architectural state of the controller.  The idle count never passes
   // the largest timeout plus one, so nine bits hold it.
   typedef struct packed {
      logic       set_mode;
      logic [3:0] digit0;
      logic [3:0] digit1;
      logic [3:0] digit2;
      logic [3:0] digit3;
      logic [3:0] blink_flags;
      logic [1:0] edit_index;
      logic [8:0] idle_ticks;
   } ctrl_state_type;

   // Modulus of the digit at a given position.
   function automatic logic [3:0] digit_modulus(input logic [1:0] idx);
      logic [3:0] m;
      unique case (idx)
         DIG_HOUR_TENS:   m = HOUR_TENS_MOD;
         DIG_MINUTE_TENS: m = MINUTE_TENS_MOD;
         default:         m = UNITS_MOD;
      endcase
      return m;
   endfunction

   // Multiply a digit by ten with shifts and one add.
   function automatic logic [6:0] times_ten(input logic [3:0] d);
      return {d, 3'b000} + {2'b00, d, 1'b0};
   endfunction

endpackage

`default_nettype wire

FILE: src/clock_digit_set_controller_top.sv
// Top level of the clock digit set controller: beat registers, state and CSR.
// A request beat passes the input register, then the response register that the
// event logic loads, before its response beat appears.
// Throughput: one event per cycle while the response side does not stall; the state
// update sits in the single combinational step between the two registers.
// Reset (synchronous, active high) empties both registers, returns to normal
// mode with all digits, blink flags, index and idle count at zero, timeout 20.
`default_nettype none

module clock_digit_set_controller_top (
   input  logic        clock,
   input  logic        reset,
   // Configuration: digit timeout in ticks.
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: edit_sample_first, edit_sample_second, set_button_level,
   //        rtc_hour[4:0], rtc_minute[5:0], two zero bits.
   input  logic [15:0] req_tdata,
   // tuser: cmd[1:0].
   input  logic [1:0]  req_tuser,
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: in_set_mode, hour_tens[1:0], hour_units[3:0], minute_tens[2:0],
   //        minute_units[3:0], blink_mask[3:0], commit_hour[4:0],
   //        commit_minute[5:0], three zero bits.
   output logic [31:0] rsp_tdata,
   // tuser: commit_valid.
   output logic        rsp_tuser
);
   import cdsc_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   req_item_type   item_ff;
   req_item_type   item_in;
   rsp_item_type   rsp_ff;
   rsp_item_type   rsp_in;
   logic           in_valid_ff;
   logic           rsp_valid_ff;
   logic [7:0]     timeout_ff;
   logic           advance;
   logic           req_beat;

   // Move the pipeline whenever the response register is free or being taken.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign req_beat   = req_tvalid && req_tready;

   assign item_in.cmd                = cmd_type'(req_tuser);
   assign item_in.edit_sample_first  = req_tdata[0];
   assign item_in.edit_sample_second = req_tdata[1];
   assign item_in.set_button_level   = req_tdata[2];
   assign item_in.rtc_hour           = req_tdata[7:3];
   assign item_in.rtc_minute         = req_tdata[13:8];

   cdsc_step u_step (
      .cur_state     (state_ff),
      .item          (item_ff),
      .timeout_ticks (timeout_ff),
      .nxt_state     (state_in),
      .rsp_item      (rsp_in)
   );

   // Control state, configuration and the valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         timeout_ff   <= TIMEOUT_RESET;
         state_ff     <= '0;
      end else begin
         if (csr_we) begin
            timeout_ff <= csr_wdata;
         end
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
            if (in_valid_ff) begin
               state_ff <= state_in;
            end
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_beat) begin
         item_ff <= item_in;
      end
      if (advance && in_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.commit_valid;
   assign rsp_tdata  = {3'b000, rsp_ff.commit_minute, rsp_ff.commit_hour,
                        rsp_ff.blink_mask, rsp_ff.minute_units, rsp_ff.minute_tens,
                        rsp_ff.hour_units, rsp_ff.hour_tens, rsp_ff.in_set_mode};

endmodule

`default_nettype wire

FILE: src/cdsc_step.sv
// Next-state and response logic for one event of the digit set controller.
`default_nettype none

module cdsc_step (
   input  cdsc_pkg::ctrl_state_type cur_state,
   input  cdsc_pkg::req_item_type   item,
   input  logic [7:0]               timeout_ticks,
   output cdsc_pkg::ctrl_state_type nxt_state,
   output cdsc_pkg::rsp_item_type   rsp_item
);
   import cdsc_pkg::*;

   logic [3:0] digits     [NUM_DIGITS];
   logic [3:0] edited     [NUM_DIGITS];
   logic [3:0] cur_digit;
   logic [3:0] inc_digit;
   logic [3:0] mod_val;
   logic [3:0] new_digit;
   logic [6:0] hour_sum;
   logic [6:0] minute_sum;
   logic [6:0] hour_fold;
   logic [6:0] minute_fold;
   logic [1:0] hr_tens;
   logic [6:0] hr_rest;
   logic [2:0] mn_tens;
   logic [6:0] mn_rest;
   logic [1:0] ld_hr_tens;
   logic [4:0] ld_hr_rest;
   logic [2:0] ld_mn_tens;
   logic [5:0] ld_mn_rest;
   logic       pressed;
   logic [8:0] idle_mid;
   logic       advance;
   logic [3:0] blink_mid;
   logic [6:0] commit_hr_sum;
   logic [6:0] commit_mn_sum;
   logic       commit;
   logic [1:0] idx;

   assign digits[0] = cur_state.digit0;
   assign digits[1] = cur_state.digit1;
   assign digits[2] = cur_state.digit2;
   assign digits[3] = cur_state.digit3;
   assign idx       = cur_state.edit_index;

   // Increment the selected digit modulo its range.
   assign cur_digit = digits[idx];
   assign inc_digit = cur_digit + 4'd1;
   assign mod_val   = digit_modulus(idx);
   assign new_digit = (inc_digit >= mod_val) ? inc_digit - mod_val : inc_digit;

   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         edited[i] = (idx == i[1:0]) ? new_digit : digits[i];
      end
   end

   // Fold hour and minute back into range; one subtract is enough.
   assign hour_sum    = times_ten(edited[0]) + {3'b000, edited[1]};
   assign minute_sum  = times_ten(edited[2]) + {3'b000, edited[3]};
   assign hour_fold   = (hour_sum >= {1'b0, HOURS_PER_DAY}) ?
                        hour_sum - {1'b0, HOURS_PER_DAY} : hour_sum;
   assign minute_fold = (minute_sum >= MINUTES_PER_HR) ?
                        minute_sum - MINUTES_PER_HR : minute_sum;

   // Split the folded values back into tens and units.
   always_comb begin
      if (hour_fold >= 7'd20) begin
         hr_tens = 2'd2;
         hr_rest = hour_fold - 7'd20;
      end else if (hour_fold >= 7'd10) begin
         hr_tens = 2'd1;
         hr_rest = hour_fold - 7'd10;
      end else begin
         hr_tens = 2'd0;
         hr_rest = hour_fold;
      end
   end

   always_comb begin
      priority if (minute_fold >= 7'd50) begin
         mn_tens = 3'd5;
         mn_rest = minute_fold - 7'd50;
      end else if (minute_fold >= 7'd40) begin
         mn_tens = 3'd4;
         mn_rest = minute_fold - 7'd40;
      end else if (minute_fold >= 7'd30) begin
         mn_tens = 3'd3;
         mn_rest = minute_fold - 7'd30;
      end else if (minute_fold >= 7'd20) begin
         mn_tens = 3'd2;
         mn_rest = minute_fold - 7'd20;
      end else if (minute_fold >= 7'd10) begin
         mn_tens = 3'd1;
         mn_rest = minute_fold - 7'd10;
      end else begin
         mn_tens = 3'd0;
         mn_rest = minute_fold;
      end
   end

   // Split the raw clock values for a load; out-of-range values keep their digits.
   always_comb begin
      priority if (item.rtc_hour >= 5'd30) begin
         ld_hr_tens = 2'd3;
         ld_hr_rest = item.rtc_hour - 5'd30;
      end else if (item.rtc_hour >= 5'd20) begin
         ld_hr_tens = 2'd2;
         ld_hr_rest = item.rtc_hour - 5'd20;
      end else if (item.rtc_hour >= 5'd10) begin
         ld_hr_tens = 2'd1;
         ld_hr_rest = item.rtc_hour - 5'd10;
      end else begin
         ld_hr_tens = 2'd0;
         ld_hr_rest = item.rtc_hour;
      end
   end

   always_comb begin
      priority if (item.rtc_minute >= 6'd60) begin
         ld_mn_tens = 3'd6;
         ld_mn_rest = item.rtc_minute - 6'd60;
      end else if (item.rtc_minute >= 6'd50) begin
         ld_mn_tens = 3'd5;
         ld_mn_rest = item.rtc_minute - 6'd50;
      end else if (item.rtc_minute >= 6'd40) begin
         ld_mn_tens = 3'd4;
         ld_mn_rest = item.rtc_minute - 6'd40;
      end else if (item.rtc_minute >= 6'd30) begin
         ld_mn_tens = 3'd3;
         ld_mn_rest = item.rtc_minute - 6'd30;
      end else if (item.rtc_minute >= 6'd20) begin
         ld_mn_tens = 3'd2;
         ld_mn_rest = item.rtc_minute - 6'd20;
      end else if (item.rtc_minute >= 6'd10) begin
         ld_mn_tens = 3'd1;
         ld_mn_rest = item.rtc_minute - 6'd10;
      end else begin
         ld_mn_tens = 3'd0;
         ld_mn_rest = item.rtc_minute;
      end
   end

   // Press clears the idle count; the timeout is checked after that.
   assign pressed   = !item.edit_sample_first && !item.edit_sample_second;
   assign idle_mid  = pressed ? 9'd0 : cur_state.idle_ticks;
   assign advance   = idle_mid > {1'b0, timeout_ticks};
   assign blink_mid = cur_state.blink_flags | (4'b0001 << idx);

   // Commit uses the digits as they stand after this tick's edit.
   assign commit_hr_sum = pressed ? {2'b00, hr_tens, 3'b000} + {4'b0000, hr_tens, 1'b0}
                                    + hr_rest
                                  : times_ten(digits[0]) + {3'b000, digits[1]};
   assign commit_mn_sum = pressed ? minute_fold
                                  : times_ten(digits[2]) + {3'b000, digits[3]};

   always_comb begin
      nxt_state = cur_state;
      commit    = 1'b0;
      unique case (item.cmd)
         CMD_LOAD: begin
            if (!cur_state.set_mode) begin
               nxt_state.digit0 = {2'b00, ld_hr_tens};
               nxt_state.digit1 = ld_hr_rest[3:0];
               nxt_state.digit2 = {1'b0, ld_mn_tens};
               nxt_state.digit3 = ld_mn_rest[3:0];
            end
         end
         CMD_ENTER: begin
            if (!item.set_button_level) begin
               nxt_state.set_mode = 1'b1;
            end
         end
         CMD_TICK: begin
            if (cur_state.set_mode) begin
               nxt_state.blink_flags = blink_mid;
               if (pressed) begin
                  nxt_state.digit0 = {2'b00, hr_tens};
                  nxt_state.digit1 = hr_rest[3:0];
                  nxt_state.digit2 = {1'b0, mn_tens};
                  nxt_state.digit3 = mn_rest[3:0];
               end
               nxt_state.idle_ticks = (advance ? 9'd0 : idle_mid) + 9'd1;
               if (advance) begin
                  nxt_state.blink_flags = blink_mid & ~(4'b0001 << idx);
                  if (idx == DIG_MINUTE_UNITS) begin
                     nxt_state.edit_index  = 2'd0;
                     nxt_state.set_mode    = 1'b0;
                     nxt_state.blink_flags = blink_mid & 4'b0110;
                     commit                = 1'b1;
                  end else begin
                     nxt_state.edit_index = idx + 2'd1;
                  end
               end
            end
         end
         CMD_NONE: begin
            nxt_state = cur_state;
         end
         default: begin
            nxt_state = cur_state;
         end
      endcase
   end

   // The response shows the state after the event.
   always_comb begin
      rsp_item.in_set_mode   = nxt_state.set_mode;
      rsp_item.hour_tens     = nxt_state.digit0[1:0];
      rsp_item.hour_units    = nxt_state.digit1;
      rsp_item.minute_tens   = nxt_state.digit2[2:0];
      rsp_item.minute_units  = nxt_state.digit3;
      rsp_item.blink_mask    = nxt_state.blink_flags;
      rsp_item.commit_valid  = commit;
      rsp_item.commit_hour   = commit ? commit_hr_sum[4:0] : 5'd0;
      rsp_item.commit_minute = commit ? commit_mn_sum[5:0] : 6'd0;
   end

endmodule

`default_nettype wire

FILE: src/cdsc_checker.sv
// Port-level assertions for the clock digit set controller and their binding.
`default_nettype none

module cdsc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser
);

   // A stalled response beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response beat changed while stalled");

   // A commit beat leaves set mode with the first and last blink bits clear.
   a_commit_exit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tdata[0] && !rsp_tdata[14] && !rsp_tdata[17])
      else $error("commit beat still in set mode or blinking");

   // Outside a commit the commit time fields read zero.
   a_commit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[28:18] == 11'd0)
      else $error("commit time present without commit");

   // In normal mode only the two middle blink bits may be set.
   a_no_blink: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[17:14] == 4'd0 || rsp_tdata[17:14] == 4'd6
      || rsp_tdata[17:14] == 4'd2 || rsp_tdata[17:14] == 4'd4)
      else $error("unexpected blink pattern in normal mode");

endmodule

bind clock_digit_set_controller_top cdsc_checker u_cdsc_checker (.*);

`default_nettype wire

FILE: verif/clock_digit_set_controller_top_tb.sv
// Self-checking testbench for the clock digit set controller top level.
`timescale 1ns / 100ps

module clock_digit_set_controller_top_tb;
   import cdsc_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned LONG_HOLD   = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [7:0]  csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;

   // Events waiting to be driven and displays waiting to come back.
   req_item_type pending_events_q[$];
   rsp_item_type expected_display_q[$];
   req_item_type req_cur = '0;

   // Shadow copy of the controller state, kept in step with accepted beats.
   logic        shadow_set_mode = 1'b0;
   logic [3:0]  shadow_digits [4] = '{4'd0, 4'd0, 4'd0, 4'd0};
   logic [3:0]  shadow_blink = '0;
   logic [1:0]  shadow_index = '0;
   logic [15:0] shadow_idle = '0;
   logic [7:0]  shadow_timeout = TIMEOUT_RESET;

   int unsigned req_gap = 0;
   int unsigned rsp_wait = 0;
   int unsigned hold_left = 0;
   logic        hold_done = 1'b0;
   int          hold_at_result = -1;
   logic        gaps_on = 1'b1;
   int unsigned events_accepted = 0;
   int          results_seen = 0;
   int unsigned commits_seen = 0;
   int unsigned mismatch_count = 0;
   int unsigned timeouts_tried = 1;
   int unsigned cycle_count = 0;

   clock_digit_set_controller_top u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Rewrite all four digits from an hour and a minute.
   function automatic void split_into_digits(int unsigned hr, int unsigned mn);
      shadow_digits[0] = 4'(hr / 10);
      shadow_digits[1] = 4'(hr % 10);
      shadow_digits[2] = 4'(mn / 10);
      shadow_digits[3] = 4'(mn % 10);
   endfunction

   // Apply one event to the shadow state and return the display it shows.
   function automatic rsp_item_type advance_display(req_item_type ev);
      rsp_item_type r;
      int unsigned idx;
      int unsigned modulus;
      int unsigned hr;
      int unsigned mn;
      r = '0;
      case (ev.cmd)
         CMD_LOAD: begin
            if (!shadow_set_mode) split_into_digits(ev.rtc_hour, ev.rtc_minute);
         end
         CMD_ENTER: begin
            if (!ev.set_button_level) shadow_set_mode = 1'b1;
         end
         CMD_TICK: begin
            if (shadow_set_mode) begin
               idx = shadow_index;
               shadow_blink[idx] = 1'b1;
               // A press needs both edit samples low; it edits, then folds the time.
               if (!ev.edit_sample_first && !ev.edit_sample_second) begin
                  shadow_idle = '0;
                  modulus = (idx == DIG_HOUR_TENS) ? HOUR_TENS_MOD :
                            (idx == DIG_MINUTE_TENS) ? MINUTE_TENS_MOD : UNITS_MOD;
                  shadow_digits[idx] = 4'((shadow_digits[idx] + 1) % modulus);
                  hr = (shadow_digits[0] * 10 + shadow_digits[1]) % HOURS_PER_DAY;
                  mn = (shadow_digits[2] * 10 + shadow_digits[3]) % MINUTES_PER_HR;
                  split_into_digits(hr, mn);
               end
               // Timeout moves to the next digit; past the last one it commits.
               if (shadow_idle > shadow_timeout) begin
                  shadow_idle = '0;
                  shadow_blink[idx] = 1'b0;
                  if (idx == DIG_MINUTE_UNITS) begin
                     shadow_index = DIG_HOUR_TENS;
                     shadow_set_mode = 1'b0;
                     hr = shadow_digits[0] * 10 + shadow_digits[1];
                     mn = shadow_digits[2] * 10 + shadow_digits[3];
                     r.commit_valid = 1'b1;
                     r.commit_hour = 5'(hr);
                     r.commit_minute = 6'(mn);
                     shadow_blink[DIG_HOUR_TENS] = 1'b0;
                  end else begin
                     shadow_index = 2'(idx + 1);
                  end
               end
               shadow_idle = shadow_idle + 16'd1;
            end
         end
         default: ;
      endcase
      r.in_set_mode = shadow_set_mode;
      r.hour_tens = shadow_digits[0][1:0];
      r.hour_units = shadow_digits[1];
      r.minute_tens = shadow_digits[2][2:0];
      r.minute_units = shadow_digits[3];
      r.blink_mask = shadow_blink;
      return r;
   endfunction

   function automatic req_item_type event_beat(cmd_type c, logic e1, logic e2, logic lvl,
                                               logic [4:0] hr, logic [5:0] mn);
      req_item_type ev;
      ev.cmd = c;
      ev.edit_sample_first = e1;
      ev.edit_sample_second = e2;
      ev.set_button_level = lvl;
      ev.rtc_hour = hr;
      ev.rtc_minute = mn;
      return ev;
   endfunction

   function automatic req_item_type random_beat();
      return event_beat(cmd_type'(2'($urandom_range(0, 3))), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)));
   endfunction

   // Queue one event; ignored command codes do not use up the budget.
   task automatic queue_event(input req_item_type ev, inout int unsigned left);
      pending_events_q.push_back(ev);
      if (ev.cmd != CMD_NONE && left > 0) left--;
   endtask

   // Editing sessions with random content, long enough to reach a commit.
   task automatic queue_random_phase(input int unsigned timeout, input int unsigned budget);
      int unsigned left;
      int unsigned press_pct;
      int unsigned ticks;
      int unsigned roll;
      logic        which;
      left = budget;
      while (left > 0) begin
         repeat ($urandom_range(0, 2)) queue_event(random_beat(), left);
         if ($urandom_range(0, 9) < 8)
            queue_event(event_beat(CMD_LOAD, 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                   5'($urandom_range(0, 23)),
                                   6'($urandom_range(0, 59))), left);
         else
            queue_event(event_beat(CMD_LOAD, 1'b1, 1'b1, 1'b1, 5'($urandom_range(0, 31)),
                                   6'($urandom_range(0, 63))), left);
         queue_event(event_beat(CMD_ENTER, 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)),
                                $urandom_range(0, 9) == 0, 5'($urandom_range(0, 31)),
                                6'($urandom_range(0, 63))), left);
         case ($urandom_range(0, 2))
            0: press_pct = 2;
            1: press_pct = 10;
            default: press_pct = 30;
         endcase
         ticks = (4 * (timeout + 2) + $urandom_range(0, 8)) * ((press_pct >= 30) ? 2 : 1);
         for (int k = 0; k < ticks && left > 0; k++) begin
            roll = $urandom_range(0, 99);
            which = 1'($urandom_range(0, 1));
            if (roll < 6)
               queue_event(random_beat(), left);
            else if (roll < 6 + press_pct)
               queue_event(event_beat(CMD_TICK, 1'b0, 1'b0, 1'($urandom_range(0, 1)),
                                      5'($urandom_range(0, 31)),
                                      6'($urandom_range(0, 63))), left);
            else if (roll < 14 + press_pct)
               queue_event(event_beat(CMD_TICK, which, !which, 1'($urandom_range(0, 1)),
                                      5'($urandom_range(0, 31)),
                                      6'($urandom_range(0, 63))), left);
            else
               queue_event(event_beat(CMD_TICK, 1'b1, 1'b1, 1'($urandom_range(0, 1)),
                                      5'($urandom_range(0, 31)),
                                      6'($urandom_range(0, 63))), left);
         end
      end
   endtask

   // Block until every queued event has been sent and every display has returned.
   task automatic wait_drained();
      @(posedge clock);
      while (pending_events_q.size() != 0 || req_tvalid || expected_display_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_timeout(input logic [7:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      shadow_timeout = value;
      timeouts_tried++;
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Request driver: presents queued events, with a random gap after each one while gaps are on.
   always @(posedge clock) begin : event_driver
      req_item_type next_ev;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_display_q.push_back(advance_display(req_cur));
            events_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_tvalid <= 1'b0;
               req_gap <= req_gap - 1;
            end else if (pending_events_q.size() > 0) begin
               next_ev = pending_events_q.pop_front();
               req_cur <= next_ev;
               req_tuser <= next_ev.cmd;
               req_tdata <= {2'b00, next_ev.rtc_minute, next_ev.rtc_hour,
                             next_ev.set_button_level, next_ev.edit_sample_second,
                             next_ev.edit_sample_first};
               req_tvalid <= 1'b1;
               req_gap <= gaps_on ? $urandom_range(0, 9) : 0;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and ready control, with one long hold-off on request.
   always @(posedge clock) begin : display_monitor
      rsp_item_type seen;
      rsp_item_type want;
      int unsigned  w;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait <= 0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.in_set_mode = rsp_tdata[0];
            seen.hour_tens = rsp_tdata[2:1];
            seen.hour_units = rsp_tdata[6:3];
            seen.minute_tens = rsp_tdata[9:7];
            seen.minute_units = rsp_tdata[13:10];
            seen.blink_mask = rsp_tdata[17:14];
            seen.commit_hour = rsp_tdata[22:18];
            seen.commit_minute = rsp_tdata[28:23];
            seen.commit_valid = rsp_tuser;
            if (expected_display_q.size() == 0) begin
               $display("%0t: unexpected response beat, expected none, actual tdata %h tuser %b",
                        $time, rsp_tdata, rsp_tuser);
               mismatch_count++;
            end else begin
               want = expected_display_q.pop_front();
               check_field("in_set_mode", want.in_set_mode, seen.in_set_mode);
               check_field("hour_tens", want.hour_tens, seen.hour_tens);
               check_field("hour_units", want.hour_units, seen.hour_units);
               check_field("minute_tens", want.minute_tens, seen.minute_tens);
               check_field("minute_units", want.minute_units, seen.minute_units);
               check_field("blink_mask", want.blink_mask, seen.blink_mask);
               check_field("commit_valid", want.commit_valid, seen.commit_valid);
               check_field("commit_hour", want.commit_hour, seen.commit_hour);
               check_field("commit_minute", want.commit_minute, seen.commit_minute);
            end
            results_seen++;
            if (rsp_tuser) commits_seen++;
         end
         if (!hold_done && results_seen == hold_at_result) begin
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (rsp_tvalid && rsp_tready) begin
            w = gaps_on ? $urandom_range(0, 9) : 0;
            if (w == 0) begin
               rsp_tready <= 1'b1;
            end else begin
               rsp_tready <= 1'b0;
               rsp_wait <= w;
            end
         end else if (!rsp_tready) begin
            if (rsp_wait > 1) rsp_wait <= rsp_wait - 1;
            else rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog on the total run length.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles.", cycle_count);
      $display("FAIL clock_digit_set_controller_top");
      $finish;
   end

   // Stimulus sequence: directed events, then random phases under several timeouts.
   initial begin : stimulus
      int unsigned phase_timeout [7];
      int unsigned phase_budget [7];
      phase_timeout = '{1, 255, 3, 0, 0, 20, 7};
      phase_budget = '{200, 300, 200, 150, 200, 200, 250};
      phase_timeout[4] = $urandom_range(2, 12);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Normal mode handling, the out-of-range load and entry into set mode.
      pending_events_q.push_back(event_beat(CMD_TICK, 1'b0, 1'b0, 1'b1, 5'd0, 6'd0));
      pending_events_q.push_back(event_beat(CMD_NONE, 1'b1, 1'b1, 1'b1, 5'd31, 6'd63));
      pending_events_q.push_back(event_beat(CMD_LOAD, 1'b0, 1'b0, 1'b0, 5'd23, 6'd59));
      pending_events_q.push_back(event_beat(CMD_LOAD, 1'b1, 1'b1, 1'b1, 5'd31, 6'd63));
      pending_events_q.push_back(event_beat(CMD_ENTER, 1'b0, 1'b0, 1'b1, 5'd0, 6'd0));
      pending_events_q.push_back(event_beat(CMD_ENTER, 1'b1, 1'b1, 1'b0, 5'd0, 6'd0));
      pending_events_q.push_back(event_beat(CMD_LOAD, 1'b1, 1'b1, 1'b0, 5'd12, 6'd34));
      pending_events_q.push_back(event_beat(CMD_ENTER, 1'b1, 1'b1, 1'b0, 5'd0, 6'd0));
      // Presses fold the loaded out-of-range time; single samples do nothing.
      pending_events_q.push_back(event_beat(CMD_TICK, 1'b0, 1'b0, 1'b0, 5'd0, 6'd0));
      pending_events_q.push_back(event_beat(CMD_TICK, 1'b0, 1'b1, 1'b0, 5'd0, 6'd0));
      pending_events_q.push_back(event_beat(CMD_TICK, 1'b1, 1'b0, 1'b0, 5'd0, 6'd0));
      pending_events_q.push_back(event_beat(CMD_TICK, 1'b1, 1'b1, 1'b1, 5'd31, 6'd63));
      pending_events_q.push_back(event_beat(CMD_TICK, 1'b0, 1'b0, 1'b1, 5'd0, 6'd0));
      wait_drained();

      // Zero timeout: advances on almost every tick, idle count carried over.
      write_timeout(8'd0);
      pending_events_q.push_back(event_beat(CMD_TICK, 1'b0, 1'b0, 1'b0, 5'd0, 6'd0));
      pending_events_q.push_back(event_beat(CMD_TICK, 1'b1, 1'b1, 1'b0, 5'd0, 6'd0));
      pending_events_q.push_back(event_beat(CMD_TICK, 1'b0, 1'b0, 1'b0, 5'd0, 6'd0));
      pending_events_q.push_back(event_beat(CMD_TICK, 1'b1, 1'b1, 1'b0, 5'd0, 6'd0));
      pending_events_q.push_back(event_beat(CMD_TICK, 1'b1, 1'b1, 1'b0, 5'd0, 6'd0));
      pending_events_q.push_back(event_beat(CMD_LOAD, 1'b0, 1'b0, 1'b0, 5'd0, 6'd0));
      pending_events_q.push_back(event_beat(CMD_ENTER, 1'b0, 1'b0, 1'b0, 5'd0, 6'd0));
      pending_events_q.push_back(event_beat(CMD_TICK, 1'b1, 1'b1, 1'b0, 5'd0, 6'd0));
      pending_events_q.push_back(event_beat(CMD_TICK, 1'b0, 1'b0, 1'b0, 5'd0, 6'd0));
      pending_events_q.push_back(event_beat(CMD_TICK, 1'b1, 1'b1, 1'b0, 5'd0, 6'd0));
      pending_events_q.push_back(event_beat(CMD_TICK, 1'b1, 1'b1, 1'b0, 5'd0, 6'd0));
      pending_events_q.push_back(event_beat(CMD_TICK, 1'b1, 1'b1, 1'b0, 5'd0, 6'd0));
      wait_drained();

      // Random phases; some run without gaps, one holds the response side off.
      for (int p = 0; p < 7; p++) begin
         write_timeout(8'(phase_timeout[p]));
         gaps_on = !(p == 3 || p == 5);
         if (p == 2) hold_at_result = results_seen + 40;
         queue_random_phase(phase_timeout[p], phase_budget[p]);
         wait_drained();
      end

      repeat (4) @(posedge clock);
      $display("Checked %0d events and %0d response beats (%0d commits) across %0d timeouts.",
               events_accepted, results_seen, commits_seen, timeouts_tried);
      if (mismatch_count == 0 && expected_display_q.size() == 0) begin
         $display("PASS clock_digit_set_controller_top");
      end else begin
         $display("FAIL clock_digit_set_controller_top");
      end
      $finish;
   end

endmodule

FILE: sim.f
src/cdsc_pkg.sv
src/cdsc_step.sv
src/clock_digit_set_controller_top.sv
src/cdsc_checker.sv
verif/clock_digit_set_controller_top_tb.sv
